[rtl/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define MRP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define MRP_ASSERT_RST(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/mrp_pkg.sv]
package mrp_pkg;

	localparam int AMT_W       = 36;
	localparam int CID_W       = 3;
	localparam int MODE_W      = 2;
	localparam int EV_W        = 2;
	localparam int CD_W        = 2;
	localparam int TMR_W       = 4;
	localparam int WIDE_W      = AMT_W + 4;
	localparam int MAX_REPORTS = 8;
	localparam int DIV_BITS    = 6;
	localparam int DIV_STEPS   = AMT_W / DIV_BITS;
	localparam int DIV_CNT_W   = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	localparam logic [AMT_W-1:0] CLAIM_MIN_RST = 36'd1436549;
	localparam logic [4:0]       DIV_TEN       = 5'd10;
	localparam logic [TMR_W-1:0] TMR_RST       = 4'd1;
	localparam logic [TMR_W-1:0] TMR_LAST      = 4'd9;
	localparam logic [TMR_W-1:0] TMR_LATE      = 4'd5;
	localparam logic [CD_W-1:0]  CD_LATE       = 2'd3;
	localparam logic [CD_W-1:0]  CD_EARLY      = 2'd2;
	localparam logic [CD_W-1:0]  CD_CLAIM      = 2'd2;

	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD   = 2'd0,
		MODE_SAMPLE = 2'd1,
		MODE_TICK   = 2'd2
	} mode_t;

	typedef enum logic [EV_W-1:0] {
		EV_NONE     = 2'd0,
		EV_RESTORED = 2'd1,
		EV_CLAIMED  = 2'd2,
		EV_LOADED   = 2'd3
	} event_t;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_SAMPLE,
		OP_PASS,
		OP_SINGLE
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV,
		ST_S_A,
		ST_S_B,
		ST_FIN,
		ST_P_RD,
		ST_P_A,
		ST_P_B,
		ST_P_C
	} state_t;

	typedef struct packed {
		logic [AMT_W-1:0] limit;
		logic [AMT_W-1:0] lim_tenth;
		logic [AMT_W-1:0] reserved;
		logic [AMT_W-1:0] peak;
		logic [CD_W-1:0]  cd;
	} rec_t;

	typedef struct packed {
		logic accept;
		logic div_step;
		logic rd_ptr;
		logic stage_a;
		logic stage_b;
		logic commit;
		logic ptr_inc;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic out_full;
		logic ptr_end;
		logic ptr_rep;
	} sts_t;

endpackage

[rtl/mrp_if.sv]
interface mrp_item_if import mrp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [CID_W-1:0]  client_index;
	logic [AMT_W-1:0]  amount;

	modport source (output valid, output mode, output client_index, output amount,
		input ready);
	modport sink (input valid, input mode, input client_index, input amount,
		output ready);
endinterface

interface mrp_res_if import mrp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CID_W-1:0] client_id;
	logic [AMT_W-1:0] reserved_now;
	logic [AMT_W-1:0] claimed;
	logic [EV_W-1:0]  event_res;
	logic             last;

	modport source (output valid, output client_id, output reserved_now, output claimed,
		output event_res, output last, input ready);
	modport sink (input valid, input client_id, input reserved_now, input claimed,
		input event_res, input last, output ready);
endinterface

[rtl/mrp_ctrl.sv]
module mrp_ctrl import mrp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic item_valid,
	output logic item_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t                 state_q;
	state_t                 state_d;
	logic [DIV_CNT_W-1:0]   cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// count divider steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == ST_DIV) begin
			cnt_q <= cnt_q + DIV_CNT_W'(1);
		end else begin
			cnt_q <= '0;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.accept = 1'b1;
					case (sts.op)
						OP_LOAD:   state_d = ST_DIV;
						OP_SAMPLE: state_d = ST_S_A;
						OP_PASS:   state_d = ST_P_RD;
						default:   state_d = ST_FIN;
					endcase
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_FIN;
				end
			end
			ST_S_A: begin
				cmd.stage_a = 1'b1;
				state_d     = ST_S_B;
			end
			ST_S_B: begin
				cmd.stage_b = 1'b1;
				state_d     = ST_FIN;
			end
			ST_FIN: begin
				if (!sts.out_full) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_P_RD: begin
				cmd.rd_ptr = 1'b1;
				state_d    = ST_P_A;
			end
			ST_P_A: begin
				cmd.stage_a = 1'b1;
				state_d     = ST_P_B;
			end
			ST_P_B: begin
				cmd.stage_b = 1'b1;
				state_d     = ST_P_C;
			end
			ST_P_C: begin
				// hold while a reported item cannot be placed
				if (!(sts.ptr_rep && sts.out_full)) begin
					cmd.commit = 1'b1;
					if (sts.ptr_end) begin
						state_d = ST_IDLE;
					end else begin
						cmd.ptr_inc = 1'b1;
						state_d     = ST_P_RD;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

[rtl/mrp_dp.sv]
module mrp_dp import mrp_pkg::*; #(
	parameter int NUM_CLIENTS = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [AMT_W-1:0]  cfg_wdata,
	input  logic [MODE_W-1:0] item_mode,
	input  logic [CID_W-1:0]  item_client_index,
	input  logic [AMT_W-1:0]  item_amount,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [CID_W-1:0]  res_client_id,
	output logic [AMT_W-1:0]  res_reserved_now,
	output logic [AMT_W-1:0]  res_claimed,
	output logic [EV_W-1:0]   res_event_res,
	output logic              res_last,
	input  cmd_t              cmd,
	output sts_t              sts
);

	localparam int IDX_W = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
	localparam int N_REP = (NUM_CLIENTS < MAX_REPORTS) ? NUM_CLIENTS : MAX_REPORTS;

	rec_t                mem_q [NUM_CLIENTS];
	logic [NUM_CLIENTS-1:0] vld_q;
	rec_t                rd_q;
	logic                rd_vld_q;
	rec_t                rec;
	logic                rd_en;
	logic [IDX_W-1:0]    rd_addr;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	rec_t                wr_rec;

	logic [AMT_W-1:0]    claim_min_q;
	logic [TMR_W-1:0]    tmr_q;
	logic [IDX_W-1:0]    ptr_q;
	op_t                 op_q;
	logic [CID_W-1:0]    id_q;
	logic [AMT_W-1:0]    amt_q;
	logic                in_range;
	op_t                 op_in;

	logic [AMT_W-1:0]    div_num_q;
	logic [3:0]          div_rem_q;
	logic [AMT_W-1:0]    div_num;
	logic [3:0]          div_rem;
	logic [4:0]          div_try;
	logic                div_qb;

	logic [WIDE_W-1:0]   wa_q;
	logic [WIDE_W-1:0]   wb_q;
	logic [WIDE_W:0]     diff_q;
	logic [WIDE_W-1:0]   sub_x;
	logic [WIDE_W-1:0]   sub_y;
	logic [AMT_W-1:0]    pk;

	logic [AMT_W-1:0]    claim;
	logic                take;
	logic [CD_W-1:0]     cd1;
	logic                emit;
	logic [CID_W-1:0]    nxt_id;
	logic [AMT_W-1:0]    nxt_res;
	logic [AMT_W-1:0]    nxt_claim;
	event_t              nxt_ev;
	logic                nxt_last;

	logic                res_vld_q;
	logic [CID_W-1:0]    res_id_q;
	logic [AMT_W-1:0]    res_rsv_q;
	logic [AMT_W-1:0]    res_clm_q;
	logic [EV_W-1:0]     res_ev_q;
	logic                res_last_q;

	// item decode
	assign in_range = 32'(item_client_index) < NUM_CLIENTS;

	always_comb begin
		case (item_mode)
			MODE_LOAD:   op_in = in_range ? OP_LOAD : OP_SINGLE;
			MODE_SAMPLE: op_in = in_range ? OP_SAMPLE : OP_SINGLE;
			MODE_TICK:   op_in = (tmr_q == '0) ? OP_PASS : OP_SINGLE;
			default:     op_in = OP_SINGLE;
		endcase
	end

	assign sts.op       = op_in;
	assign sts.out_full = res_vld_q && !res_ready;
	assign sts.ptr_end  = ptr_q == IDX_W'(NUM_CLIENTS - 1);
	assign sts.ptr_rep  = 32'(ptr_q) < 32'(N_REP);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= op_in;
			amt_q <= item_amount;
			id_q  <= (item_mode == MODE_LOAD || item_mode == MODE_SAMPLE) ?
				item_client_index : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			claim_min_q <= CLAIM_MIN_RST;
		end else if (cfg_we) begin
			claim_min_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tmr_q <= TMR_RST;
		end else if (cmd.accept && item_mode == MODE_TICK && tmr_q != '0) begin
			tmr_q <= (tmr_q == TMR_LAST) ? '0 : tmr_q + TMR_W'(1);
		end else if (cmd.commit && op_q == OP_PASS && sts.ptr_end) begin
			tmr_q <= TMR_RST;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (cmd.accept) begin
			ptr_q <= '0;
		end else if (cmd.ptr_inc) begin
			ptr_q <= ptr_q + IDX_W'(1);
		end
	end

	// client table
	assign rd_en   = cmd.rd_ptr || (cmd.accept && in_range &&
		(item_mode == MODE_LOAD || item_mode == MODE_SAMPLE));
	assign rd_addr = cmd.rd_ptr ? ptr_q : IDX_W'(item_client_index);
	assign wr_en   = cmd.commit && op_q != OP_SINGLE;
	assign wr_addr = (op_q == OP_PASS) ? ptr_q : IDX_W'(id_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_rec;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	assign rec = rd_vld_q ? rd_q : '0;

	// divide amount by ten, a few bits per step
	always_comb begin
		div_num = div_num_q;
		div_rem = div_rem_q;
		div_try = '0;
		div_qb  = 1'b0;
		for (int k = 0; k < DIV_BITS; k++) begin
			div_try = {div_rem, div_num[AMT_W-1]};
			div_qb  = div_try >= DIV_TEN;
			div_num = {div_num[AMT_W-2:0], div_qb};
			div_rem = div_qb ? 4'(div_try - DIV_TEN) : div_try[3:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			div_num_q <= item_amount;
			div_rem_q <= '0;
		end else if (cmd.div_step) begin
			div_num_q <= div_num;
			div_rem_q <= div_rem;
		end
	end

	// scaled operands, then their difference
	assign pk = (rec.peak > rec.lim_tenth) ? rec.peak : rec.lim_tenth;

	always_ff @(posedge clk) begin
		if (cmd.stage_a) begin
			if (op_q == OP_PASS) begin
				wa_q <= WIDE_W'({pk, 2'b00}) + WIDE_W'(pk);
				wb_q <= WIDE_W'({rec.reserved, 2'b00});
			end else begin
				wa_q <= WIDE_W'({amt_q, 3'b000}) + WIDE_W'({amt_q, 1'b0});
				wb_q <= WIDE_W'({rec.reserved, 3'b000}) + WIDE_W'(rec.reserved);
			end
		end
	end

	assign sub_x = (op_q == OP_PASS) ? wb_q : wa_q;
	assign sub_y = (op_q == OP_PASS) ? wa_q : wb_q;

	always_ff @(posedge clk) begin
		if (cmd.stage_b) begin
			diff_q <= {1'b0, sub_x} - {1'b0, sub_y};
		end
	end

	// update and result
	assign claim = diff_q[AMT_W+1:2];
	assign cd1   = (rec.cd != '0) ? rec.cd - CD_W'(1) : '0;
	assign take  = !diff_q[WIDE_W] && (diff_q != '0) && (claim > claim_min_q) &&
		(cd1 == '0);

	always_comb begin
		wr_rec    = rec;
		nxt_id    = id_q;
		nxt_res   = '0;
		nxt_claim = '0;
		nxt_ev    = EV_NONE;
		nxt_last  = 1'b1;
		case (op_q)
			OP_LOAD: begin
				wr_rec.limit     = amt_q;
				wr_rec.lim_tenth = div_num_q;
				wr_rec.reserved  = amt_q;
				wr_rec.cd        = '0;
				nxt_res          = amt_q;
				nxt_ev           = EV_LOADED;
			end
			OP_SAMPLE: begin
				if (!diff_q[WIDE_W]) begin
					wr_rec.cd       = (tmr_q >= TMR_LATE) ? CD_LATE : CD_EARLY;
					wr_rec.reserved = rec.limit;
					nxt_ev          = EV_RESTORED;
				end
				if (amt_q > rec.peak) begin
					wr_rec.peak = amt_q;
				end
				nxt_res = wr_rec.reserved;
			end
			OP_PASS: begin
				wr_rec.cd   = cd1;
				wr_rec.peak = '0;
				if (take) begin
					wr_rec.cd       = CD_CLAIM;
					wr_rec.reserved = rec.reserved - claim;
					nxt_claim       = claim;
					nxt_ev          = EV_CLAIMED;
				end
				nxt_id   = CID_W'(ptr_q);
				nxt_res  = wr_rec.reserved;
				nxt_last = 32'(ptr_q) == 32'(N_REP - 1);
			end
			default: begin
				nxt_last = 1'b1;
			end
		endcase
	end

	assign emit = cmd.commit && (op_q != OP_PASS || sts.ptr_rep);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (emit) begin
			res_vld_q <= 1'b1;
		end else if (res_ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_id_q   <= nxt_id;
			res_rsv_q  <= nxt_res;
			res_clm_q  <= nxt_claim;
			res_ev_q   <= nxt_ev;
			res_last_q <= nxt_last;
		end
	end

	assign res_valid        = res_vld_q;
	assign res_client_id    = res_id_q;
	assign res_reserved_now = res_rsv_q;
	assign res_claimed      = res_clm_q;
	assign res_event_res    = res_ev_q;
	assign res_last         = res_last_q;

endmodule

[rtl/memory_reclaim_policy_unit.sv]
// Memory reclaim policy for NUM_CLIENTS clients.
// Channel item (valid/ready): mode, client_index, amount. Mode 0 loads a limit,
// mode 1 gives a usage sample, mode 2 is the end-of-round tick.
// Channel res (valid/ready): client_id, reserved_now, claimed, event_res, last.
// Every item gives one result, except a tick that starts a reclaim pass, which
// reports up to MAX_REPORTS clients from 0 in order, last set on the final one.
// claim_min is written through cfg_we/cfg_wdata. The user must write it only
// while the block is idle; the block itself does not enforce this.
// A sample takes a scale and a subtract stage, a load six divide-by-ten steps;
// a reclaim pass takes each client through a table read, a scale stage, a
// subtract stage and an update stage on the one client table port. A result, or
// the last of a pass, shows in the same cycle as the block is ready again.
// The result sits in an output register, so an item is taken while the previous
// result still waits; a stalled receiver holds the block at its next result.
// Reset clears all client entries to zero, sets the round timer to one and
// claim_min to its default; the block is ready in the first cycle after reset.
module memory_reclaim_policy_unit import mrp_pkg::*; #(
	parameter int NUM_CLIENTS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [AMT_W-1:0] cfg_wdata,
	mrp_item_if.sink         item,
	mrp_res_if.source        res
);

	cmd_t cmd;
	sts_t sts;

	mrp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	mrp_dp #(
		.NUM_CLIENTS (NUM_CLIENTS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_wdata         (cfg_wdata),
		.item_mode         (item.mode),
		.item_client_index (item.client_index),
		.item_amount       (item.amount),
		.res_valid         (res.valid),
		.res_ready         (res.ready),
		.res_client_id     (res.client_id),
		.res_reserved_now  (res.reserved_now),
		.res_claimed       (res.claimed),
		.res_event_res     (res.event_res),
		.res_last          (res.last),
		.cmd               (cmd),
		.sts               (sts)
	);

endmodule

[rtl/mrp_chk.sv]
`include "assert_macros.svh"

module mrp_chk import mrp_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              item_valid,
	input logic              item_ready,
	input logic [MODE_W-1:0] item_mode,
	input logic              res_valid,
	input logic              res_ready,
	input logic [CID_W-1:0]  res_client_id,
	input logic [AMT_W-1:0]  res_reserved_now,
	input logic [AMT_W-1:0]  res_claimed,
	input logic [EV_W-1:0]   res_event_res,
	input logic              res_last
);

	`MRP_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(res_client_id) && $stable(res_reserved_now) && $stable(res_claimed) && $stable(res_event_res) && $stable(res_last), "stalled result changed")
	`MRP_ASSERT(a_pass_busy, res_valid && !res_last |-> !item_ready, "item taken during a reclaim pass")
	`MRP_ASSERT(a_load_busy, item_valid && item_ready && item_mode == MODE_LOAD |=> !item_ready, "load did not occupy the block")
	`MRP_ASSERT_RST(a_rst_quiet, !arst_n |=> !res_valid, "result shown during reset")

endmodule

bind memory_reclaim_policy_unit mrp_chk u_mrp_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.item_valid       (item.valid),
	.item_ready       (item.ready),
	.item_mode        (item.mode),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_client_id    (res.client_id),
	.res_reserved_now (res.reserved_now),
	.res_claimed      (res.claimed),
	.res_event_res    (res.event_res),
	.res_last         (res.last)
);

[test/memory_reclaim_policy_unit_test.sv]
module memory_reclaim_policy_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import mrp_pkg::*;

	localparam int                NUM_CLIENTS = 8;
	localparam int                DIR_ROWS    = 22;
	localparam int                PHASES      = 5;
	localparam int                PHASE_ITEMS = 80;
	localparam int                HOLD_CYCLES = 300;
	localparam logic [MODE_W-1:0] MODE_UNDEF  = 2'd3;
	localparam logic [AMT_W-1:0]  AMT_MAX     = 36'hF_FFFF_FFFF;

	typedef struct packed {
		logic [CID_W-1:0] cid;
		logic [AMT_W-1:0] resv;
		logic [AMT_W-1:0] clm;
		event_t           ev;
		logic             last;
	} res_t;

	typedef struct packed {
		logic [MODE_W-1:0] m;
		logic [CID_W-1:0]  c;
		logic [AMT_W-1:0]  a;
		logic              typed;
		res_t              want;
	} dir_row_t;

	localparam res_t NO_RES   = '{3'd0, 36'd0, 36'd0, EV_NONE, 1'b0};
	localparam res_t ZERO_RES = '{3'd0, 36'd0, 36'd0, EV_NONE, 1'b1};

	localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
		'{MODE_SAMPLE, 3'd0, 36'd0,        1'b0, NO_RES},
		'{MODE_LOAD,   3'd0, AMT_MAX,      1'b1, '{3'd0, AMT_MAX, 36'd0, EV_LOADED, 1'b1}},
		'{MODE_LOAD,   3'd1, 36'd0,        1'b1, '{3'd1, 36'd0, 36'd0, EV_LOADED, 1'b1}},
		'{MODE_LOAD,   3'd7, 36'd20000000, 1'b1,
			'{3'd7, 36'd20000000, 36'd0, EV_LOADED, 1'b1}},
		'{MODE_LOAD,   3'd3, 36'd10000000, 1'b1,
			'{3'd3, 36'd10000000, 36'd0, EV_LOADED, 1'b1}},
		'{MODE_UNDEF,  3'd5, AMT_MAX,      1'b1, ZERO_RES},
		'{MODE_SAMPLE, 3'd0, AMT_MAX,      1'b0, NO_RES},
		'{MODE_SAMPLE, 3'd7, 36'd1000,     1'b0, NO_RES},
		'{MODE_SAMPLE, 3'd3, 36'd9000000,  1'b0, NO_RES},
		'{MODE_SAMPLE, 3'd1, 36'd5,        1'b0, NO_RES},
		'{MODE_TICK,   3'd0, 36'd0,        1'b1, ZERO_RES},
		'{MODE_TICK,   3'd7, AMT_MAX,      1'b1, ZERO_RES},
		'{MODE_TICK,   3'd2, 36'd0,        1'b1, ZERO_RES},
		'{MODE_TICK,   3'd0, 36'd0,        1'b1, ZERO_RES},
		'{MODE_TICK,   3'd0, 36'd0,        1'b1, ZERO_RES},
		'{MODE_SAMPLE, 3'd3, 36'd9500000,  1'b0, NO_RES},
		'{MODE_TICK,   3'd0, 36'd0,        1'b1, ZERO_RES},
		'{MODE_TICK,   3'd0, 36'd0,        1'b1, ZERO_RES},
		'{MODE_TICK,   3'd0, 36'd0,        1'b1, ZERO_RES},
		'{MODE_TICK,   3'd0, 36'd0,        1'b1, ZERO_RES},
		'{MODE_TICK,   3'd0, 36'd0,        1'b0, NO_RES},
		'{MODE_TICK,   3'd0, 36'd0,        1'b1, ZERO_RES}
	};

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [AMT_W-1:0] cfg_wdata;

	mrp_item_if item_ch ();
	mrp_res_if  res_ch ();

	memory_reclaim_policy_unit #(
		.NUM_CLIENTS(NUM_CLIENTS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.item     (item_ch),
		.res      (res_ch)
	);

	logic [AMT_W-1:0] lim_tab  [NUM_CLIENTS] = '{default: '0};
	logic [AMT_W-1:0] resv_tab [NUM_CLIENTS] = '{default: '0};
	logic [AMT_W-1:0] peak_tab [NUM_CLIENTS] = '{default: '0};
	logic [CD_W-1:0]  cool_tab [NUM_CLIENTS] = '{default: '0};
	logic [TMR_W-1:0] rnd_tmr   = TMR_RST;
	logic [AMT_W-1:0] min_claim = CLAIM_MIN_RST;

	res_t step_out    [$];
	res_t pending_res [$];
	res_t got_res;
	res_t want_res;

	int idle_pct      = 28;
	bit hold_req      = 1'b0;
	int errors        = 0;
	int items_sent    = 0;
	int results_seen  = 0;
	int passes_run    = 0;
	int claims_seen   = 0;

	function automatic void reclaim_step(input logic [MODE_W-1:0] m,
		input logic [CID_W-1:0] c, input logic [AMT_W-1:0] a);
		logic [63:0] a64;
		logic [63:0] r64;
		logic [63:0] pk;
		logic [63:0] fl;
		logic [63:0] clm;
		longint      num;
		res_t        r;
		int          i;

		step_out.delete();
		r   = ZERO_RES;
		a64 = 64'(a);
		case (m)
			MODE_LOAD: begin
				lim_tab[c]  = a;
				resv_tab[c] = a;
				cool_tab[c] = '0;
				r.cid  = c;
				r.resv = a;
				r.ev   = EV_LOADED;
				step_out.push_back(r);
			end
			MODE_SAMPLE: begin
				r64 = 64'(resv_tab[c]);
				if (a64 * 10 >= r64 * 9) begin
					cool_tab[c] = (rnd_tmr >= TMR_LATE) ? CD_LATE : CD_EARLY;
					resv_tab[c] = lim_tab[c];
					r.ev        = EV_RESTORED;
				end
				if (a > peak_tab[c])
					peak_tab[c] = a;
				r.cid  = c;
				r.resv = resv_tab[c];
				step_out.push_back(r);
			end
			MODE_TICK: begin
				if (rnd_tmr != 0) begin
					rnd_tmr = TMR_W'((rnd_tmr + 1) % 10);
					step_out.push_back(r);
				end else begin
					passes_run++;
					for (i = 0; i < NUM_CLIENTS; i++) begin
						r = NO_RES;
						if (cool_tab[i] != 0)
							cool_tab[i] = cool_tab[i] - CD_W'(1);
						fl = 64'(lim_tab[i]) / 10;
						pk = (64'(peak_tab[i]) > fl) ? 64'(peak_tab[i]) : fl;
						peak_tab[i] = '0;
						r64 = 64'(resv_tab[i]);
						num = longint'(r64 * 4) - longint'(pk * 5);
						if (num > 0) begin
							clm = num / 4;
							if (clm > 0 && clm > min_claim && cool_tab[i] == 0) begin
								cool_tab[i] = CD_CLAIM;
								resv_tab[i] = resv_tab[i] - clm[AMT_W-1:0];
								r.clm = clm[AMT_W-1:0];
								r.ev  = EV_CLAIMED;
							end
						end
						r.cid  = CID_W'(i);
						r.resv = resv_tab[i];
						r.last = (i == NUM_CLIENTS - 1);
						step_out.push_back(r);
					end
					rnd_tmr = TMR_RST;
				end
			end
			default: step_out.push_back(r);
		endcase
	endfunction

	function automatic logic [AMT_W-1:0] rand_amt();
		logic [AMT_W-1:0] v;

		case ($urandom_range(0, 4))
			0: begin
				v[31:0]  = $urandom();
				v[35:32] = 4'($urandom_range(0, 15));
			end
			1: v = AMT_W'($urandom_range(0, 1000));
			2: v = AMT_W'($urandom_range(0, 50000000));
			3: v = $urandom_range(0, 1) ? AMT_MAX : '0;
			default: v = AMT_W'($urandom_range(1000000, 40000000));
		endcase
		return v;
	endfunction

	function automatic logic [AMT_W-1:0] usage_amt(input logic [CID_W-1:0] c);
		logic [63:0] r64;
		logic [63:0] t;
		logic [63:0] v;

		r64 = 64'(resv_tab[c]);
		case ($urandom_range(0, 3))
			0: begin
				t = (r64 * 9 + 9) / 10;
				v = (t == 0) ? 64'd0 : t - 1 + $urandom_range(0, 2);
			end
			1: v = (r64 * $urandom_range(0, 100)) / 100;
			2: v = ({28'd0, lim_tab[c]} / 10) * $urandom_range(0, 30) / 10;
			default: v = 64'(rand_amt());
		endcase
		return v[AMT_W-1:0];
	endfunction

	task automatic send_item(input logic [MODE_W-1:0] m, input logic [CID_W-1:0] c,
		input logic [AMT_W-1:0] a, input logic typed, input res_t want);
		while ($urandom_range(0, 99) < idle_pct) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.mode         <= m;
		item_ch.client_index <= c;
		item_ch.amount       <= a;
		do
			@(posedge clk);
		while (!item_ch.ready);
		reclaim_step(m, c, a);
		if (typed)
			pending_res.push_back(want);
		else
			foreach (step_out[k])
				pending_res.push_back(step_out[k]);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic set_claim_min(input logic [AMT_W-1:0] v);
		item_ch.valid <= 1'b0;
		while (pending_res.size() != 0)
			@(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		min_claim = v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1000000;
		$display("RESULT: ERROR");
		$finish;
	end

	// receiver: random back-pressure, plus one long hold-off on request
	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			res_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready) begin
			got_res = '{res_ch.client_id, res_ch.reserved_now, res_ch.claimed,
				event_t'(res_ch.event_res), res_ch.last};
			if (pending_res.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: client %0d reserved %0d claimed %0d event %0d",
						got_res.cid, got_res.resv, got_res.clm, got_res.ev);
			end else begin
				want_res = pending_res.pop_front();
				results_seen++;
				if (got_res.cid !== want_res.cid || got_res.resv !== want_res.resv ||
						got_res.clm !== want_res.clm || got_res.ev !== want_res.ev ||
						got_res.last !== want_res.last) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: got client %0d reserved %0d claimed %0d event %0d last %0b; expected client %0d reserved %0d claimed %0d event %0d last %0b",
							got_res.cid, got_res.resv, got_res.clm, got_res.ev, got_res.last,
							want_res.cid, want_res.resv, want_res.clm, want_res.ev,
							want_res.last);
				end else if (want_res.ev == EV_CLAIMED) begin
					claims_seen++;
				end
			end
		end
	end

	initial begin
		logic [AMT_W-1:0]  thr [PHASES];
		logic [MODE_W-1:0] m;
		logic [CID_W-1:0]  c;
		logic [AMT_W-1:0]  a;
		int                pick;

		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_wdata            = '0;
		item_ch.valid        = 1'b0;
		item_ch.mode         = MODE_LOAD;
		item_ch.client_index = '0;
		item_ch.amount       = '0;
		thr = '{36'd0, AMT_MAX, CLAIM_MIN_RST, 36'd0, 36'd1};
		thr[3] = AMT_W'($urandom_range(0, 20000000));

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROWS; i++)
			send_item(DIR_TAB[i].m, DIR_TAB[i].c, DIR_TAB[i].a, DIR_TAB[i].typed,
				DIR_TAB[i].want);

		for (int ph = 0; ph < PHASES; ph++) begin
			set_claim_min(thr[ph]);
			idle_pct = (ph == 3) ? 0 : 28;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				// stall the receiver while items keep coming
				if (ph == 1 && k == 20)
					hold_req = 1'b1;
				pick = $urandom_range(0, 99);
				c = CID_W'($urandom_range(0, NUM_CLIENTS - 1));
				if (pick < 12) begin
					m = MODE_LOAD;
					a = rand_amt();
				end else if (pick < 60) begin
					m = MODE_SAMPLE;
					a = usage_amt(c);
				end else if (pick < 95) begin
					m = MODE_TICK;
					a = rand_amt();
				end else begin
					m = MODE_UNDEF;
					a = rand_amt();
				end
				send_item(m, c, a, 1'b0, NO_RES);
			end
		end
		item_ch.valid <= 1'b0;

		while (pending_res.size() != 0)
			@(posedge clk);
		repeat (4 * NUM_CLIENTS + 8) @(posedge clk);

		$display("%0d items sent, %0d results checked, %0d reclaim passes, %0d claims taken",
			items_sent, results_seen, passes_run, claims_seen);
		$display("claim floors used: zero, full scale, default, random, one; %0d mismatches",
			errors);
		if (errors == 0 && pending_res.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl
rtl/mrp_pkg.sv
rtl/mrp_if.sv
rtl/mrp_ctrl.sv
rtl/mrp_dp.sv
rtl/memory_reclaim_policy_unit.sv
rtl/mrp_chk.sv
test/memory_reclaim_policy_unit_test.sv
